// File: rtl/ogg_page_length_walker_defines.svh
// Assertion macros used by the checker of the Ogg page walker.
`ifndef OGG_PAGE_LENGTH_WALKER_DEFINES_SVH
`define OGG_PAGE_LENGTH_WALKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OPW_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OPW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/opw_pkg.sv
package opw_pkg;

   localparam int TOTAL_BITS = 40;
   localparam int OUT_BITS   = 40;
   localparam int PAGE_BITS  = 16;
   localparam int ACC_BITS   = 17;
   localparam int BODY_BITS  = 16;
   localparam int WIDE_BITS  = 64;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = ((PAGE_BITS + OUT_BITS + 7) / 8) * 8;

   localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_SEGS   = 2'd1;
   localparam logic [1:0] PH_BODY   = 2'd2;

   localparam logic [4:0] CAPTURE_LEN  = 5'd5;
   localparam logic [4:0] SEG_COUNT_AT = 5'd26;
   localparam logic [ACC_BITS-1:0] HDR_LEN = 17'd27;

   localparam logic STATUS_PAGE = 1'b0;
   localparam logic STATUS_STOP = 1'b1;

   typedef struct packed {
      logic                 status;
      logic [PAGE_BITS-1:0] page_len;
      logic [OUT_BITS-1:0]  total_size;
   } opw_result_type;

   // Capture pattern "OggS" followed by structure version zero.
   function automatic logic [7:0] capture_byte(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0:    val = 8'h4F;
         3'd1:    val = 8'h67;
         3'd2:    val = 8'h67;
         3'd3:    val = 8'h53;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [OUT_BITS-1:0] out_total(input logic [TOTAL_BITS-1:0] t);
      logic [WIDE_BITS-1:0] wide;
      wide = WIDE_BITS'(t);
      return (wide > WIDE_BITS'(OUT_MAX)) ? OUT_MAX : wide[OUT_BITS-1:0];
   endfunction

endpackage

// File: rtl/opw_core.sv
module opw_core
   import opw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step_en,
   input  logic [7:0]     data_byte,
   input  logic           new_file,
   output logic           emit,
   output opw_result_type result
);

   logic [1:0]            phase_ff,  phase_in;
   logic [4:0]            idx_ff,    idx_in;
   logic [7:0]            segs_ff,   segs_in;
   logic [ACC_BITS-1:0]   acc_ff,    acc_in;
   logic [BODY_BITS-1:0]  body_ff,   body_in;
   logic [TOTAL_BITS-1:0] total_ff,  total_in;
   logic                  stopped_ff, stopped_in;

   logic [1:0]            phase_e;
   logic [4:0]            idx_e, hidx;
   logic [7:0]            segs_e, seg_dec;
   logic [ACC_BITS-1:0]   acc_e, acc_add, acc_fin;
   logic [BODY_BITS-1:0]  body_e, body_add, body_dec;
   logic [TOTAL_BITS-1:0] total_e, total_sat;
   logic [TOTAL_BITS:0]   total_sum;
   logic                  stopped_e, finish;

   always_comb begin
      // A new file clears the walker before this byte is looked at.
      phase_e   = new_file ? PH_HEADER : phase_ff;
      idx_e     = new_file ? 5'd0 : idx_ff;
      segs_e    = new_file ? 8'd0 : segs_ff;
      acc_e     = new_file ? '0 : acc_ff;
      body_e    = new_file ? '0 : body_ff;
      total_e   = new_file ? '0 : total_ff;
      stopped_e = new_file ? 1'b0 : stopped_ff;

      seg_dec  = segs_e - 8'd1;
      acc_add  = acc_e + ACC_BITS'(data_byte);
      body_add = body_e + BODY_BITS'(data_byte);
      body_dec = body_e - BODY_BITS'(1);
      hidx     = (phase_e == PH_HEADER) ? idx_e : 5'd0;

      phase_in   = phase_e;
      idx_in     = idx_e;
      segs_in    = segs_e;
      acc_in     = acc_e;
      body_in    = body_e;
      stopped_in = stopped_e;
      acc_fin    = acc_e;
      finish     = 1'b0;
      emit       = 1'b0;
      result.status   = STATUS_PAGE;
      result.page_len = '0;

      if (!stopped_e) begin
         unique case (phase_e)
            PH_SEGS: begin
               acc_in  = acc_add;
               body_in = body_add;
               segs_in = seg_dec;
               if (seg_dec == 8'd0) begin
                  if (body_add == '0) begin
                     finish  = 1'b1;
                     acc_fin = acc_add;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               body_in = body_dec;
               if (body_dec == '0) begin
                  finish = 1'b1;
               end
            end
            default: begin
               // The unused phase code behaves as the start of a header.
               phase_in = PH_HEADER;
               idx_in   = hidx;
               if (phase_e != PH_HEADER) begin
                  segs_in = 8'd0;
                  acc_in  = '0;
                  body_in = '0;
               end
               if (hidx < CAPTURE_LEN) begin
                  if (data_byte != capture_byte(hidx[2:0])) begin
                     stopped_in = 1'b1;
                     idx_in     = 5'd0;
                     segs_in    = 8'd0;
                     acc_in     = '0;
                     body_in    = '0;
                     emit       = 1'b1;
                     result.status = STATUS_STOP;
                  end else begin
                     idx_in = hidx + 5'd1;
                  end
               end else if (hidx == SEG_COUNT_AT) begin
                  segs_in = data_byte;
                  acc_in  = HDR_LEN + ACC_BITS'(data_byte);
                  body_in = '0;
                  idx_in  = 5'd0;
                  if (data_byte == 8'd0) begin
                     finish  = 1'b1;
                     acc_fin = HDR_LEN;
                  end else begin
                     phase_in = PH_SEGS;
                  end
               end else begin
                  idx_in = hidx + 5'd1;
               end
            end
         endcase
      end

      total_sum = {1'b0, total_e} + (TOTAL_BITS + 1)'(acc_fin);
      total_sat = total_sum[TOTAL_BITS] ? '1 : total_sum[TOTAL_BITS-1:0];
      total_in  = total_e;

      if (finish) begin
         emit     = 1'b1;
         total_in = total_sat;
         result.page_len = acc_fin[PAGE_BITS-1:0];
         phase_in = PH_HEADER;
         idx_in   = 5'd0;
         segs_in  = 8'd0;
         acc_in   = '0;
         body_in  = '0;
      end

      result.total_size = out_total(total_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         idx_ff     <= 5'd0;
         segs_ff    <= 8'd0;
         acc_ff     <= '0;
         body_ff    <= '0;
         total_ff   <= '0;
         stopped_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         idx_ff     <= idx_in;
         segs_ff    <= segs_in;
         acc_ff     <= acc_in;
         body_ff    <= body_in;
         total_ff   <= total_in;
         stopped_ff <= stopped_in;
      end
   end

endmodule

// File: rtl/ogg_page_length_walker.sv
// Ogg page length walker.
// The request channel carries one stream byte per beat in req_tdata; req_tuser set on a
// beat clears the walker, the running total and the stop latch, and that byte becomes
// offset 0 of a page. The response channel gives one beat for each completed page
// (rsp_tuser low, page size and running total in rsp_tdata) and one beat when the
// capture pattern does not match (rsp_tuser high, page size zero); after a stop, bytes
// are swallowed silently until a beat with req_tuser set.
// One byte is taken every cycle while the request side does not stall. A byte waits in
// an input register until the walker logic does its page step on it, and a response
// then waits in the registered output. The byte-wise counter update
// in the walker sets the rate of one byte per cycle.
// A synchronous reset empties both registers and puts the walker at the start of a
// page with a zero total. When the receiver stalls, a response waits in the output
// register; the input register keeps moving on bytes that give no response, and the
// request side stalls only when a byte that does give one meets a full output.
module ogg_page_length_walker
   import opw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // [7:0] data_byte
   input  logic                  req_tuser,  // [0] new_file
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [15:0] page_len, [55:16] total_size
   output logic                  rsp_tuser   // [0] status
);

   logic                  in_valid_ff;
   logic [7:0]            in_byte_ff;
   logic                  in_new_ff;
   logic                  step;
   logic                  emit;
   logic                  out_free;
   opw_result_type        result;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_user_ff;

   opw_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step),
      .data_byte (in_byte_ff),
      .new_file  (in_new_ff),
      .emit      (emit),
      .result    (result)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[7:0];
         in_new_ff  <= req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_data_ff <= RSP_DATA_W'({result.total_size, result.page_len});
         rsp_user_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: rtl/opw_checker.sv
`include "ogg_page_length_walker_defines.svh"

module opw_checker
   import opw_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic                 req_beat;
   logic [PAGE_BITS-1:0] page_len;
   logic [OUT_BITS-1:0]  total_size;

   assign req_beat   = req_tvalid && req_tready && (req_tuser || !req_tuser)
                       && (req_tdata == req_tdata);
   assign page_len   = rsp_tdata[PAGE_BITS-1:0];
   assign total_size = rsp_tdata[PAGE_BITS+OUT_BITS-1:PAGE_BITS];

   // A stop beat never carries a page size.
   `OPW_ASSERT_NOW(a_stop_no_size, clock, reset, rsp_tvalid && rsp_tuser == STATUS_STOP,
      page_len == '0, "stop beat with nonzero page size")

   // Every page holds at least its fixed 27-byte header.
   `OPW_ASSERT_NOW(a_page_min, clock, reset, rsp_tvalid && rsp_tuser == STATUS_PAGE,
      page_len >= PAGE_BITS'(HDR_LEN), "page shorter than its header")

   // The running total already includes the page it is reported with.
   `OPW_ASSERT_NOW(a_total_covers, clock, reset, rsp_tvalid && rsp_tuser == STATUS_PAGE,
      total_size >= OUT_BITS'(page_len), "running total below page size")

   // A response that shows up after an idle cycle is either a stop or a whole page.
   `OPW_ASSERT_NEXT(a_no_early_rsp, clock, reset, !req_beat && !rsp_tvalid,
      !rsp_tvalid || rsp_tuser == STATUS_STOP || page_len >= PAGE_BITS'(HDR_LEN),
      "response appeared with an impossible page size")

   // A stalled response beat holds.
   `OPW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response changed")

endmodule

bind ogg_page_length_walker opw_checker u_opw_checker (.*);

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
   import opw_pkg::*;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       new_file;
      logic       drain_first;
   } stream_byte_type;

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_WINDOWED} rx_mode_type;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_TARGET = 1900;
   localparam logic [TOTAL_BITS-1:0] TOTAL_SAT = '1;
   localparam logic [7:0] OGG_CAPTURE [5] = '{8'h4F, 8'h67, 8'h67, 8'h53, 8'h00};

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   stream_byte_type feed_q[$];
   opw_result_type  page_results_q[$];

   bit feed_loaded = 1'b0;
   bit feed_done   = 1'b0;
   bit failed      = 1'b0;
   int cycle_count = 0;

   // Generator bookkeeping: whether the walker is latched stopped or has lost page alignment.
   bit gen_stopped = 1'b0;
   bit gen_resync  = 1'b0;
   bit drain_next  = 1'b0;
   int live_bytes  = 0;

   // Predicted walker state.
   logic [1:0]            walk_phase     = PH_HEADER;
   logic [4:0]            walk_hdr_idx   = '0;
   logic [7:0]            walk_segs_left = '0;
   logic [ACC_BITS-1:0]   walk_page_acc  = '0;
   logic [BODY_BITS-1:0]  walk_body_left = '0;
   logic [TOTAL_BITS-1:0] walk_total     = '0;
   logic                  walk_stopped   = 1'b0;

   int          send_burst = 1;
   int          send_gap   = 0;
   rx_mode_type rx_mode    = RX_OPEN;
   int          rx_left    = 0;

   always #6 clock = ~clock;

   ogg_page_length_walker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   function automatic void walk_clear();
      walk_phase     = PH_HEADER;
      walk_hdr_idx   = '0;
      walk_segs_left = '0;
      walk_page_acc  = '0;
      walk_body_left = '0;
   endfunction

   function automatic logic [OUT_BITS-1:0] reported_total();
      return (64'(walk_total) > 64'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(walk_total);
   endfunction

   function automatic void close_page();
      logic [TOTAL_BITS-1:0] size;
      opw_result_type        res;
      size = TOTAL_BITS'(walk_page_acc);
      if (walk_total > TOTAL_SAT - size) begin
         walk_total = TOTAL_SAT;
      end else begin
         walk_total = walk_total + size;
      end
      res.status     = STATUS_PAGE;
      res.page_len   = walk_page_acc[PAGE_BITS-1:0];
      res.total_size = reported_total();
      page_results_q.push_back(res);
      walk_clear();
   endfunction

   function automatic void walk_byte(input logic [7:0] b, input logic new_file);
      opw_result_type res;
      if (new_file) begin
         walk_clear();
         walk_total   = '0;
         walk_stopped = 1'b0;
      end
      if (walk_stopped) begin
         return;
      end
      if (walk_phase == PH_SEGS) begin
         walk_page_acc  = walk_page_acc + b;
         walk_body_left = walk_body_left + b;
         walk_segs_left = walk_segs_left - 1'b1;
         if (walk_segs_left == 0) begin
            if (walk_body_left == 0) begin
               close_page();
            end else begin
               walk_phase = PH_BODY;
            end
         end
      end else if (walk_phase == PH_BODY) begin
         walk_body_left = walk_body_left - 1'b1;
         if (walk_body_left == 0) begin
            close_page();
         end
      end else begin
         // The spare phase code behaves as the start of a header.
         if (walk_phase != PH_HEADER) begin
            walk_clear();
         end
         if (walk_hdr_idx < CAPTURE_LEN && b != OGG_CAPTURE[walk_hdr_idx[2:0]]) begin
            walk_stopped = 1'b1;
            walk_clear();
            res.status     = STATUS_STOP;
            res.page_len   = '0;
            res.total_size = reported_total();
            page_results_q.push_back(res);
         end else if (walk_hdr_idx == SEG_COUNT_AT) begin
            walk_segs_left = b;
            walk_page_acc  = HDR_LEN + b;
            walk_body_left = '0;
            walk_hdr_idx   = '0;
            if (b == 0) begin
               close_page();
            end else begin
               walk_phase = PH_SEGS;
            end
         end else begin
            walk_hdr_idx = walk_hdr_idx + 1'b1;
         end
      end
   endfunction

   function automatic void put(input logic [7:0] b, input logic new_file);
      stream_byte_type s;
      s.data_byte   = b;
      s.new_file    = new_file;
      s.drain_first = drain_next;
      drain_next = 1'b0;
      if (new_file) begin
         gen_stopped = 1'b0;
      end
      if (!gen_stopped) begin
         live_bytes++;
      end
      feed_q.push_back(s);
   endfunction

   // Queues one page. A capture byte can be corrupted (fault_at) and the page can be cut
   // short (cut_at); -1 disables either.
   function automatic void add_page(input int nseg, input int seg_max, input int fault_at,
                                    input int cut_at, input logic new_file);
      logic [7:0] pg[$];
      int         body;
      logic [7:0] seg_val;
      logic       start_nf;
      body = 0;
      for (int i = 0; i < 5; i++) begin
         pg.push_back(OGG_CAPTURE[i]);
      end
      repeat (21) pg.push_back(8'($urandom_range(0, 255)));
      pg.push_back(8'(nseg));
      repeat (nseg) begin
         seg_val = 8'($urandom_range(0, seg_max));
         body += seg_val;
         pg.push_back(seg_val);
      end
      repeat (body) pg.push_back(8'($urandom_range(0, 255)));
      if (fault_at >= 0) begin
         pg[fault_at] = pg[fault_at] ^ 8'($urandom_range(1, 255));
      end
      start_nf   = new_file || gen_resync || gen_stopped;
      gen_resync = 1'b0;
      for (int i = 0; i < pg.size(); i++) begin
         if (i == cut_at) begin
            gen_resync = 1'b1;
            break;
         end
         put(pg[i], (i == 0) && start_nf);
         if (i == fault_at) begin
            gen_stopped = 1'b1;
         end
      end
   endfunction

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      stream_byte_type nxt;
      logic            take;
      logic            show;
      take = req_tvalid && req_tready;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (take) begin
            walk_byte(req_tdata[7:0], req_tuser);
         end
         show = req_tvalid && !take;
         if (!show) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (feed_q.size() != 0 &&
                         !(feed_q[0].drain_first && page_results_q.size() != 0)) begin
               nxt = feed_q.pop_front();
               req_tdata <= nxt.data_byte;
               req_tuser <= nxt.new_file;
               show = 1'b1;
               send_burst--;
               if (send_burst <= 0) begin
                  if ($urandom_range(0, 5) == 0) begin
                     send_burst = $urandom_range(100, 400);
                     send_gap   = 0;
                  end else begin
                     send_burst = $urandom_range(4, 40);
                     send_gap   = $urandom_range(0, 4);
                  end
               end
            end
         end
         req_tvalid <= show;
         if (feed_loaded && feed_q.size() == 0 && !show) begin
            feed_done <= 1'b1;
         end
      end
   end

   // Receiver: checks each beat against the oldest prediction and stalls in its own modes.
   always @(posedge clock) begin
      opw_result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (page_results_q.size() == 0) begin
               $display("%0t: unexpected beat, status %0d page_len %0d total_size %0d",
                        $time, rsp_tuser, rsp_tdata[15:0], rsp_tdata[55:16]);
               failed = 1'b1;
            end else begin
               want = page_results_q.pop_front();
               if (rsp_tuser !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_tuser);
                  failed = 1'b1;
               end
               if (rsp_tdata[15:0] !== want.page_len) begin
                  $display("%0t: page_len expected %0d, got %0d",
                           $time, want.page_len, rsp_tdata[15:0]);
                  failed = 1'b1;
               end
               if (rsp_tdata[55:16] !== want.total_size) begin
                  $display("%0t: total_size expected %0d, got %0d",
                           $time, want.total_size, rsp_tdata[55:16]);
                  failed = 1'b1;
               end
            end
         end
         if (rx_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
         end
         rx_left--;
         case (rx_mode)
            RX_OPEN:   rsp_tready <= 1'b1;
            RX_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_tready <= (rx_left % 5) == 0;
            default:   rsp_tready <= (rx_left % 16) >= 10;
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int  kind;
      int  pick;
      bit  big_done;
      big_done = 1'b0;

      // Directed: short pages, a mismatch at every capture position, aborted pages.
      add_page(0, 0, -1, -1, 1'b0);
      add_page(3, 0, -1, -1, 1'b0);
      add_page(1, 2, -1, -1, 1'b0);
      for (int k = 0; k < 5; k++) begin
         add_page(0, 0, k, k + 2, 1'b0);
      end
      add_page(2, 3, -1, 10, 1'b0);
      add_page(1, 4, -1, -1, 1'b1);
      add_page(0, 0, 0, 1, 1'b1);

      live_bytes = 0;
      drain_next = 1'b1;
      while (live_bytes < RANDOM_TARGET) begin
         if (!big_done && live_bytes > RANDOM_TARGET / 2) begin
            // One page with the largest segment count.
            drain_next = 1'b1;
            add_page(255, 1, -1, -1, 1'b0);
            big_done = 1'b1;
         end
         if ($urandom_range(0, 49) == 0) begin
            drain_next = 1'b1;
         end
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               add_page($urandom_range(0, 5), $urandom_range(0, 12), -1, -1,
                        $urandom_range(0, 19) == 0);
            end else if (pick == 7) begin
               add_page($urandom_range(1, 3), 255, -1, -1, 1'b0);
            end else if (pick == 8) begin
               add_page($urandom_range(100, 255), 1, -1, -1, 1'b0);
            end else begin
               add_page(0, 0, -1, -1, $urandom_range(0, 3) == 0);
            end
         end else if (kind < 80) begin
            add_page($urandom_range(0, 3), $urandom_range(0, 8), $urandom_range(0, 4),
                     ($urandom_range(0, 1) == 0) ? -1 : int'($urandom_range(5, 30)),
                     $urandom_range(0, 7) == 0);
         end else if (kind < 90) begin
            add_page($urandom_range(0, 5), $urandom_range(0, 12), -1,
                     $urandom_range(1, 40), 1'b0);
         end else begin
            repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)),
                                              $urandom_range(0, 15) == 0);
            gen_resync = 1'b1;
         end
      end
      feed_loaded = 1'b1;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      wait (feed_done);
      while (page_results_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!failed) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl
rtl/opw_pkg.sv
rtl/opw_core.sv
rtl/ogg_page_length_walker.sv
rtl/opw_checker.sv
dv/tb.sv
